@@ design/debounced_mode_key_encoder_macros.svh @@
// Assertion macros used by the debounced mode key encoder top level.
`ifndef DEBOUNCED_MODE_KEY_ENCODER_MACROS_SVH
`define DEBOUNCED_MODE_KEY_ENCODER_MACROS_SVH

// Checked at every rising clock edge while reset is released.
`define DBMK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define DBMK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/dbmk_pkg.sv @@
// Package with the types, constants and command table of the debounced mode key encoder.
package dbmk_pkg;

  localparam int NUM_KEYS = 4;
  localparam int KEY_W = 2;
  localparam int QUIET_W = 16;
  localparam int CMD_W = 4;
  localparam int MODE_W = 2;

  localparam logic [QUIET_W-1:0] QUIET_RESET = 16'd100;
  localparam logic [QUIET_W-1:0] QUIET_MAX = 16'hFFFF;

  localparam logic [KEY_W-1:0] KEY_UP = 2'd0;
  localparam logic [KEY_W-1:0] KEY_DOWN = 2'd1;
  localparam logic [KEY_W-1:0] KEY_ACTION = 2'd2;
  localparam logic [KEY_W-1:0] KEY_MODE = 2'd3;

  localparam logic [MODE_W-1:0] MODE_VOLUME = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BRIGHT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEDIA = 2'd2;
  localparam logic [MODE_W-1:0] LAST_MODE = MODE_MEDIA;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE        = 4'd0,
    CMD_VOL_UP      = 4'd1,
    CMD_BRIGHT_UP   = 4'd2,
    CMD_NEXT        = 4'd3,
    CMD_VOL_DOWN    = 4'd4,
    CMD_BRIGHT_DOWN = 4'd5,
    CMD_PREV        = 4'd6,
    CMD_MUTE        = 4'd7,
    CMD_PLAY        = 4'd8
  } cmd_e;

  typedef struct packed {
    logic differs;
    logic rising;
    cmd_e command;
  } lane_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] stable;
    logic [MODE_W-1:0]   mode;
    cmd_e                command;
  } merge_t;

  function automatic cmd_e key_command(input logic [KEY_W-1:0] key,
                                       input logic [MODE_W-1:0] mode);
    cmd_e cmd;
    cmd = CMD_NONE;
    case (key)
      KEY_UP: begin
        case (mode)
          MODE_VOLUME: cmd = CMD_VOL_UP;
          MODE_BRIGHT: cmd = CMD_BRIGHT_UP;
          MODE_MEDIA:  cmd = CMD_NEXT;
          default:     cmd = CMD_NONE;
        endcase
      end
      KEY_DOWN: begin
        case (mode)
          MODE_VOLUME: cmd = CMD_VOL_DOWN;
          MODE_BRIGHT: cmd = CMD_BRIGHT_DOWN;
          MODE_MEDIA:  cmd = CMD_PREV;
          default:     cmd = CMD_NONE;
        endcase
      end
      KEY_ACTION: begin
        case (mode)
          MODE_VOLUME: cmd = CMD_MUTE;
          MODE_MEDIA:  cmd = CMD_PLAY;
          default:     cmd = CMD_NONE;
        endcase
      end
      default: cmd = CMD_NONE;
    endcase
    return cmd;
  endfunction

endpackage

@@ design/dbmk_if.sv @@
// Stream interfaces for the sample input channel and the result output channel.
interface dbmk_in_if;
  logic valid;
  logic ready;
  logic up_level;
  logic down_level;
  logic action_level;
  logic mode_level;

  modport source (output valid, output up_level, output down_level, output action_level,
                  output mode_level, input ready);
  modport sink (input valid, input up_level, input down_level, input action_level,
                input mode_level, output ready);
endinterface

interface dbmk_out_if;
  import dbmk_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [MODE_W-1:0] current_mode;

  modport source (output valid, output command, output current_mode, input ready);
  modport sink (input valid, input command, input current_mode, output ready);
endinterface

@@ design/dbmk_lane.sv @@
// One button lane: compares the raw level with the stable level and looks up its command.
module dbmk_lane #(
  parameter int KeyIdx = 0
) (
  input  logic                      raw_i,
  input  logic                      stable_i,
  input  logic [dbmk_pkg::MODE_W-1:0] mode_i,
  output dbmk_pkg::lane_t           lane_o
);
  import dbmk_pkg::*;

  always_comb begin
    lane_o.differs = raw_i ^ stable_i;
    lane_o.rising  = raw_i & ~stable_i;
    lane_o.command = key_command(KEY_W'(KeyIdx), mode_i);
  end

endmodule

@@ design/dbmk_merge.sv @@
// Merging stage: the first differing lane in priority order updates stable levels and mode.
module dbmk_merge (
  input  dbmk_pkg::lane_t                     lanes_i [dbmk_pkg::NUM_KEYS],
  input  logic                                quiet_ok_i,
  input  logic [dbmk_pkg::NUM_KEYS-1:0]       stable_i,
  input  logic [dbmk_pkg::MODE_W-1:0]         mode_i,
  output dbmk_pkg::merge_t                    result_o
);
  import dbmk_pkg::*;

  always_comb begin
    logic found;
    found = 1'b0;
    result_o.stable  = stable_i;
    result_o.mode    = mode_i;
    result_o.command = CMD_NONE;
    if (quiet_ok_i) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (!found && lanes_i[i].differs) begin
          found = 1'b1;
          result_o.stable[i] = ~stable_i[i];
          if (lanes_i[i].rising) begin
            if (KEY_W'(i) == KEY_MODE) begin
              result_o.mode = (mode_i >= LAST_MODE) ? MODE_VOLUME : mode_i + 1'b1;
            end else begin
              result_o.command = lanes_i[i].command;
            end
          end
        end
      end
    end
  end

endmodule

@@ design/debounced_mode_key_encoder.sv @@
// Top level of the debounced mode key encoder with shared quiet counter and output buffer.
//
// Each input transaction on in_i is one sample tick with the raw levels of the up, down,
// action and mode buttons. Every accepted transaction yields exactly one output
// transaction on out_o with the command code (zero when there is no event) and the mode
// in force after that tick.
// The four button lanes and the merging stage work in the same cycle as the accept; each
// result is registered in the output register or, while that holds an untaken result, in
// the second result register; throughput one transaction per cycle while in_i.ready is high.
// A second result register holds one further result while the receiver stalls, so a
// sample is still accepted while a finished result waits; in_i.ready falls only when
// both result registers are full, and it rises again on the cycle after out_o takes one.
// cfg_we_i writes quiet_ticks from cfg_wdata_i; a level change is accepted once the
// shared quiet counter exceeds it.
// Reset sets quiet_ticks to 100, clears the previous raw levels, stable levels, quiet
// counter and mode, and empties the result registers.
`include "debounced_mode_key_encoder_macros.svh"

module debounced_mode_key_encoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dbmk_pkg::QUIET_W-1:0]   cfg_wdata_i,
  dbmk_in_if.sink                        in_i,
  dbmk_out_if.source                     out_o
);
  import dbmk_pkg::*;

  logic [QUIET_W-1:0]  quiet_ticks_q;
  logic [NUM_KEYS-1:0] prev_q;
  logic [NUM_KEYS-1:0] stable_q;
  logic [QUIET_W-1:0]  count_q, count_d;
  logic [MODE_W-1:0]   mode_q;

  logic                out_valid_q;
  logic [CMD_W-1:0]    out_cmd_q;
  logic [MODE_W-1:0]   out_mode_q;
  logic                skid_valid_q;
  logic [CMD_W-1:0]    skid_cmd_q;
  logic [MODE_W-1:0]   skid_mode_q;

  logic [NUM_KEYS-1:0] raw;
  logic                accept;
  logic                take;
  logic                quiet_ok;
  lane_t               lanes [NUM_KEYS];
  merge_t              merged;

  assign raw = {in_i.mode_level, in_i.action_level, in_i.down_level, in_i.up_level};
  assign in_i.ready = ~skid_valid_q;
  assign accept = in_i.valid & in_i.ready;
  assign take = out_valid_q & out_o.ready;

  always_comb begin
    if (raw != prev_q) begin
      count_d = '0;
    end else if (count_q != QUIET_MAX) begin
      count_d = count_q + 1'b1;
    end else begin
      count_d = count_q;
    end
  end

  assign quiet_ok = count_d > quiet_ticks_q;

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
    dbmk_lane #(
      .KeyIdx(g)
    ) u_lane (
      .raw_i   (raw[g]),
      .stable_i(stable_q[g]),
      .mode_i  (mode_q),
      .lane_o  (lanes[g])
    );
  end

  dbmk_merge u_merge (
    .lanes_i   (lanes),
    .quiet_ok_i(quiet_ok),
    .stable_i  (stable_q),
    .mode_i    (mode_q),
    .result_o  (merged)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_ticks_q <= QUIET_RESET;
    end else if (cfg_we_i) begin
      quiet_ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      stable_q <= '0;
      count_q  <= '0;
      mode_q   <= MODE_VOLUME;
    end else if (accept) begin
      prev_q   <= raw;
      stable_q <= merged.stable;
      count_q  <= count_d;
      mode_q   <= merged.mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (take) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
        end
      end else if (accept) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && skid_valid_q) begin
      out_cmd_q  <= skid_cmd_q;
      out_mode_q <= skid_mode_q;
    end else if (accept && (take || !out_valid_q)) begin
      out_cmd_q  <= merged.command;
      out_mode_q <= merged.mode;
    end
    if (accept && out_valid_q && !take) begin
      skid_cmd_q  <= merged.command;
      skid_mode_q <= merged.mode;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.command      = out_cmd_q;
  assign out_o.current_mode = out_mode_q;

  `DBMK_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_q || out_valid_q,
                      "Second result register holds a result while the first is empty.")
  `DBMK_ASSERT(a_raw_change_holds_stable, accept && (raw != prev_q) |=> $stable(stable_q),
               "Stable levels changed on a tick with a raw change.")
  `DBMK_ASSERT(a_one_key_per_tick, $countones(stable_q ^ $past(stable_q)) <= 1,
               "More than one stable level changed in one tick.")
  `DBMK_ASSERT_ALWAYS(a_mode_range, mode_q <= LAST_MODE,
                      "Mode index is out of range.")
  `DBMK_ASSERT(a_mode_step, !$stable(mode_q) |-> $past(accept) && $past(quiet_ok),
               "Mode changed without an accepted quiet tick.")

endmodule
